[rtl/tsfq_pkg.sv]
package tsfq_pkg;

  // Default number of entries the queue can hold across both stacks.
  localparam int unsigned DEPTH_DEF = 16;

  // Payload widths fixed by the interface.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned OCC_W  = 5;

  // Operation codes carried by one command beat.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2
  } op_e;

  // Status codes reported with every result beat.
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

endpackage

[rtl/two_stack_fifo_queue.sv]
// Channel   Direction  Ports                                         Beat
// command   in         start_i, busy_o, operation_i, push_value_i    start_i && !busy_o
// result    out        done_o, read_value_o, status_o,               done_o, one cycle
//                      queue_empty_o, occupancy_o
//
// Every command gives one result beat on done_o in a later cycle; the receiver cannot stall.
// A push, a rejected push, an empty pop or peek, or an unused code answers in the next cycle.
// A pop or peek served from the output stack is answered via the output memory read register.
// A pop or peek that finds the output stack empty moves the n entries of the input
// stack over at one per cycle through the input memory read port.
// Reset clears both counts at once; no clearing pass.
module two_stack_fifo_queue #(
  parameter int unsigned DEPTH = tsfq_pkg::DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [1:0]                         operation_i,
  input  logic signed [tsfq_pkg::DATA_W-1:0] push_value_i,
  output logic                               done_o,
  output logic signed [tsfq_pkg::DATA_W-1:0] read_value_o,
  output logic [1:0]                         status_o,
  output logic                               queue_empty_o,
  output logic [tsfq_pkg::OCC_W-1:0]         occupancy_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned DW = tsfq_pkg::DATA_W;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_XFER  = 3'b010,
    S_OREAD = 3'b100
  } state_e;

  state_e            state_q, state_d;
  tsfq_pkg::op_e     op_q, op_d;
  logic [CW-1:0]     in_cnt_q, in_cnt_d;
  logic [CW-1:0]     out_cnt_q, out_cnt_d;
  logic [CW-1:0]     in_dec, out_dec, total_q, total_d;

  // Stack memories and their ports.
  logic [DW-1:0]     in_mem [DEPTH];
  logic [DW-1:0]     out_mem [DEPTH];
  logic              in_we, in_re, out_we, out_re;
  logic [AW-1:0]     in_waddr, in_raddr, out_waddr, out_raddr;
  logic [DW-1:0]     in_rdata, out_rdata, out_wdata;

  // Result beat.
  logic              res_fire;
  logic [DW-1:0]     res_val;
  tsfq_pkg::status_e res_st;
  logic              done_q;
  logic [DW-1:0]     read_value_q;
  tsfq_pkg::status_e status_q;
  logic              empty_q;
  logic [tsfq_pkg::OCC_W-1:0] occ_q;

  assign in_dec  = in_cnt_q - CW'(1);
  assign out_dec = out_cnt_q - CW'(1);
  assign total_q = in_cnt_q + out_cnt_q;
  assign total_d = in_cnt_d + out_cnt_d;

  // Sequencer: push, top read, or transfer of the input stack onto the output stack.
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    in_cnt_d  = in_cnt_q;
    out_cnt_d = out_cnt_q;
    in_we     = 1'b0;
    in_waddr  = in_cnt_q[AW-1:0];
    in_re     = 1'b0;
    in_raddr  = in_dec[AW-1:0];
    out_we    = 1'b0;
    out_waddr = out_cnt_q[AW-1:0];
    out_wdata = in_rdata;
    out_re    = 1'b0;
    out_raddr = out_dec[AW-1:0];
    res_fire  = 1'b0;
    res_val   = '0;
    res_st    = tsfq_pkg::ST_OK;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d = tsfq_pkg::op_e'(operation_i);
          unique case (tsfq_pkg::op_e'(operation_i))
            tsfq_pkg::OP_PUSH: begin
              res_fire = 1'b1;
              if (total_q == CW'(DEPTH)) begin
                res_st = tsfq_pkg::ST_FULL;
              end else begin
                in_we    = 1'b1;
                in_cnt_d = in_cnt_q + CW'(1);
              end
            end
            tsfq_pkg::OP_POP, tsfq_pkg::OP_PEEK: begin
              if (out_cnt_q != '0) begin
                out_re  = 1'b1;
                state_d = S_OREAD;
                if (tsfq_pkg::op_e'(operation_i) == tsfq_pkg::OP_POP) begin
                  out_cnt_d = out_dec;
                end
              end else if (in_cnt_q != '0) begin
                // Start the transfer with the top of the input stack.
                in_re    = 1'b1;
                in_cnt_d = in_dec;
                state_d  = S_XFER;
              end else begin
                res_fire = 1'b1;
                res_st   = tsfq_pkg::ST_EMPTY;
              end
            end
            default: begin
              res_fire = 1'b1;
            end
          endcase
        end
      end
      S_XFER: begin
        if (in_cnt_q != '0) begin
          // Write the entry read last cycle and fetch the next one.
          out_we    = 1'b1;
          out_cnt_d = out_cnt_q + CW'(1);
          in_re     = 1'b1;
          in_cnt_d  = in_dec;
        end else begin
          // The last entry moved is the oldest; a pop never stores it.
          res_fire = 1'b1;
          res_val  = in_rdata;
          state_d  = S_IDLE;
          if (op_q == tsfq_pkg::OP_PEEK) begin
            out_we    = 1'b1;
            out_cnt_d = out_cnt_q + CW'(1);
          end
        end
      end
      S_OREAD: begin
        res_fire = 1'b1;
        res_val  = out_rdata;
        state_d  = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign busy_o = (state_q != S_IDLE);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= tsfq_pkg::OP_PUSH;
      in_cnt_q  <= '0;
      out_cnt_q <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      op_q      <= op_d;
      in_cnt_q  <= in_cnt_d;
      out_cnt_q <= out_cnt_d;
      done_q    <= res_fire;
    end
  end

  // Result payload registers.
  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      read_value_q <= res_val;
      status_q     <= res_st;
      empty_q      <= (total_d == '0);
      occ_q        <= tsfq_pkg::OCC_W'(total_d);
    end
  end

  // Input stack memory.
  always_ff @(posedge clk_i) begin
    if (in_we) begin
      in_mem[in_waddr] <= push_value_i;
    end
    if (in_re) begin
      in_rdata <= in_mem[in_raddr];
    end
  end

  // Output stack memory.
  always_ff @(posedge clk_i) begin
    if (out_we) begin
      out_mem[out_waddr] <= out_wdata;
    end
    if (out_re) begin
      out_rdata <= out_mem[out_raddr];
    end
  end

  assign done_o        = done_q;
  assign read_value_o  = read_value_q;
  assign status_o      = status_q;
  assign queue_empty_o = empty_q;
  assign occupancy_o   = occ_q;

  // The two stacks together never hold more than the queue depth.
  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CW'(DEPTH))
    else $error("queue occupancy exceeds depth");

  // A transfer never starts while the output stack holds entries that the transfer
  // would bury.
  a_xfer_onto_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE && state_d == S_XFER) |-> (out_cnt_q == '0))
    else $error("transfer started onto a non-empty output stack");

  // An accepted push with room grows the input stack by one.
  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && operation_i == tsfq_pkg::OP_PUSH && total_q != CW'(DEPTH))
    |=> (in_cnt_q == $past(in_cnt_q) + CW'(1)))
    else $error("push did not advance the input stack");

  // A pop or peek with entries on the output stack gets its beat via the output memory read.
  a_top_read_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && out_cnt_q != '0 &&
     (operation_i == tsfq_pkg::OP_POP || operation_i == tsfq_pkg::OP_PEEK))
    |=> (!done_o ##1 done_o))
    else $error("top read did not produce a result beat");

endmodule

[sim/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam int unsigned QDEPTH     = tsfq_pkg::DEPTH_DEF;
  localparam int unsigned DATA_W     = tsfq_pkg::DATA_W;
  localparam int unsigned OCC_W      = tsfq_pkg::OCC_W;
  localparam int          NUM_RANDOM = 800;
  localparam int          IDLE_PCT   = 22;
  localparam int          STALL_MAX  = 1000;
  localparam int          DRAIN_CYC  = 2 * QDEPTH + 8;

  // Code 3 has no operation; the block must answer it with an ok beat and no state change.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // One result beat as the queue should report it.
  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic [1:0]        status;
    logic              queue_empty;
    logic [OCC_W-1:0]  occupancy;
  } queue_beat_t;

  // Shadow copy of the two stacks plus the list of result beats still owed by the block.
  class queue_scoreboard;
    logic [DATA_W-1:0] in_stack [QDEPTH];
    logic [DATA_W-1:0] out_stack[QDEPTH];
    int unsigned       in_cnt;
    int unsigned       out_cnt;
    queue_beat_t       pending_results[$];
    int                mismatches;
    int                pushes_ok;
    int                full_rejects;
    int                empty_errors;
    int                reads_ok;
    int                refills;

    function new();
      in_cnt       = 0;
      out_cnt      = 0;
      mismatches   = 0;
      pushes_ok    = 0;
      full_rejects = 0;
      empty_errors = 0;
      reads_ok     = 0;
      refills      = 0;
    endfunction

    // Apply one accepted command to the shadow stacks and queue up the beat it should yield.
    function void note_command(logic [1:0] op, logic [DATA_W-1:0] val);
      queue_beat_t beat;
      int unsigned total;
      beat.read_value = '0;
      beat.status     = tsfq_pkg::ST_OK;
      if (op == tsfq_pkg::OP_PUSH) begin
        if (in_cnt + out_cnt >= QDEPTH) begin
          beat.status = tsfq_pkg::ST_FULL;
          full_rejects++;
        end else begin
          in_stack[in_cnt] = val;
          in_cnt++;
          pushes_ok++;
        end
      end else if (op == tsfq_pkg::OP_POP || op == tsfq_pkg::OP_PEEK) begin
        // An empty output stack is refilled from the input stack, which reverses the order.
        if (out_cnt == 0 && in_cnt != 0) begin
          refills++;
          while (in_cnt > 0 && out_cnt < QDEPTH) begin
            in_cnt--;
            out_stack[out_cnt] = in_stack[in_cnt];
            out_cnt++;
          end
        end
        if (out_cnt == 0) begin
          beat.status = tsfq_pkg::ST_EMPTY;
          empty_errors++;
        end else begin
          beat.read_value = out_stack[out_cnt-1];
          reads_ok++;
          if (op == tsfq_pkg::OP_POP) out_cnt--;
        end
      end
      total            = in_cnt + out_cnt;
      beat.queue_empty = (total == 0);
      beat.occupancy   = total[OCC_W-1:0];
      pending_results.push_back(beat);
    endfunction

    // Compare one result beat from the block with the oldest outstanding beat.
    function void check_result(logic [DATA_W-1:0] rd, logic [1:0] st, logic emp,
                               logic [OCC_W-1:0] occ);
      queue_beat_t exp_beat;
      if (pending_results.size() == 0) begin
        $error("result beat with no command outstanding");
        mismatches++;
        return;
      end
      exp_beat = pending_results.pop_front();
      if (rd !== exp_beat.read_value) begin
        $error("read_value: expected %h, got %h", exp_beat.read_value, rd);
        mismatches++;
      end
      if (st !== exp_beat.status) begin
        $error("status: expected %0d, got %0d", exp_beat.status, st);
        mismatches++;
      end
      if (emp !== exp_beat.queue_empty) begin
        $error("queue_empty: expected %0d, got %0d", exp_beat.queue_empty, emp);
        mismatches++;
      end
      if (occ !== exp_beat.occupancy) begin
        $error("occupancy: expected %0d, got %0d", exp_beat.occupancy, occ);
        mismatches++;
      end
    endfunction
  endclass

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [1:0]               operation_i;
  logic signed [DATA_W-1:0] push_value_i;
  logic                     done_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [1:0]               status_o;
  logic                     queue_empty_o;
  logic [OCC_W-1:0]         occupancy_o;

  queue_scoreboard sb;
  logic            no_idle;
  int              stall_cycles = 0;
  int              commands_sent;

  two_stack_fifo_queue #(
    .DEPTH(QDEPTH)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .operation_i  (operation_i),
    .push_value_i (push_value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .queue_empty_o(queue_empty_o),
    .occupancy_o  (occupancy_o)
  );

  // Free-running clock, 20 ns period.
  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Every result beat is checked at the edge that takes it.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      sb.check_result(read_value_o, status_o, queue_empty_o, occupancy_o);
    end
  end

  // Give up when neither a command nor a result beat has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_MAX) begin
        $display("TB_ERROR");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Half random words, half the sign and magnitude extremes.
  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       pick_value = 32'h8000_0000;
      1:       pick_value = 32'h7FFF_FFFF;
      2:       pick_value = 32'h0000_0000;
      3:       pick_value = 32'hFFFF_FFFF;
      default: pick_value = $urandom;
    endcase
  endfunction

  // Present one command from a falling edge, with random idle cycles ahead of it, and hold it
  // until the block takes the beat. Returns at the falling edge after acceptance.
  task automatic send_command(input logic [1:0] op, input logic [DATA_W-1:0] val);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      start_i      <= 1'b0;
      operation_i  <= 2'($urandom_range(3));
      push_value_i <= $urandom;
      @(negedge clk_i);
    end
    start_i      <= 1'b1;
    operation_i  <= op;
    push_value_i <= val;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_command(op, val);
    commands_sent++;
    @(negedge clk_i);
  endtask

  // Random command mix whose push share depends on the phase, so the queue keeps filling up
  // to full and draining down to empty.
  task automatic send_random(input int push_pct);
    int          r;
    logic [1:0]  op;
    r = $urandom_range(99);
    if (r < 2) begin
      op = OP_UNUSED;
    end else if (r < 2 + push_pct) begin
      op = tsfq_pkg::OP_PUSH;
    end else if ($urandom_range(3) == 0) begin
      op = tsfq_pkg::OP_PEEK;
    end else begin
      op = tsfq_pkg::OP_POP;
    end
    send_command(op, pick_value());
  endtask

  initial begin
    sb            = new();
    no_idle       = 1'b0;
    commands_sent = 0;
    rst_ni        = 1'b0;
    start_i       = 1'b0;
    operation_i   = tsfq_pkg::OP_PUSH;
    push_value_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: errors on an empty queue, the unused code, value extremes, a refill that
    // reverses two entries, a pop served while the input stack holds data, then fill to full.
    send_command(tsfq_pkg::OP_POP,  32'h1234_5678);
    send_command(tsfq_pkg::OP_PEEK, 32'hFFFF_FFFF);
    send_command(OP_UNUSED,         32'hFFFF_FFFF);
    send_command(tsfq_pkg::OP_PUSH, 32'h8000_0000);
    send_command(tsfq_pkg::OP_PUSH, 32'h7FFF_FFFF);
    send_command(tsfq_pkg::OP_PEEK, 32'h0000_0000);
    send_command(tsfq_pkg::OP_POP,  32'h0000_0000);
    send_command(tsfq_pkg::OP_PUSH, 32'h0000_0000);
    send_command(tsfq_pkg::OP_POP,  32'hFFFF_FFFF);
    for (int i = 0; i < QDEPTH; i++) begin
      send_command(tsfq_pkg::OP_PUSH, (i % 2) ? 32'hFFFF_FFFF : pick_value());
    end
    send_command(tsfq_pkg::OP_POP, 32'h5555_AAAA);

    // Random: phases of filling, draining, balanced traffic and alternation.
    for (int k = 0; k < NUM_RANDOM; k++) begin
      no_idle = (k >= 400 && k < 550);
      case ((k / 100) % 4)
        0:       send_random(72);
        1:       send_random(30);
        2:       send_random(50);
        default: send_random((k % 20 < 10) ? 85 : 15);
      endcase
    end
    start_i <= 1'b0;

    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    $display("Sent %0d commands: %0d pushes stored, %0d rejected as full, %0d reads served.",
             commands_sent, sb.pushes_ok, sb.full_rejects, sb.reads_ok);
    $display("Empty-queue errors: %0d, output stack refills: %0d, mismatches: %0d.",
             sb.empty_errors, sb.refills, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
